// ===== rtl/sdiv_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed divider package
// Shared widths, defaults and the per-transaction control word that travels
// down the divider cell chain.
// ----------------------------------------------------------------------------
package sdiv_pkg;

  // Width of every operand and result port.
  localparam int FIELD_WIDTH = 64;

  // Default operand width used inside the divider.
  localparam int DATA_WIDTH_DEF = 64;

  // Control bits that ride along with each transaction.
  typedef struct packed {
    logic neg;   // result must be negated
    logic dz;    // divisor was zero, result forced to zero
  } sdiv_ctl_t;

endpackage

// ===== rtl/sdiv_prep.sv =====
// ----------------------------------------------------------------------------
// Signed divider operand stage
// Reduces both operands to magnitudes, forms the result sign and the zero
// divisor flag, and loads the first entry of the cell chain.
// ----------------------------------------------------------------------------
module sdiv_prep import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FIELD_WIDTH-1:0] dividend,
  input  logic [FIELD_WIDTH-1:0] divisor,
  output logic                   valid,
  input  logic                   out_stall,
  output sdiv_ctl_t              ctl,
  output logic [DATA_WIDTH-1:0]  rem,
  output logic [DATA_WIDTH-1:0]  nq,
  output logic [DATA_WIDTH-1:0]  den
);

  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;

  assign a = dividend[DATA_WIDTH-1:0];
  assign b = divisor[DATA_WIDTH-1:0];

  // The most negative value negates to itself, which is its exact magnitude
  // when read as unsigned.
  assign mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
  assign mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;

  assign in_stall = valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ctl.neg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      ctl.dz  <= (mag_b == '0);
      rem     <= '0;
      nq      <= mag_a;
      den     <= mag_b;
    end
  end

endmodule

// ===== rtl/sdiv_cell.sv =====
// ----------------------------------------------------------------------------
// Signed divider cell
// One restoring shift-subtract step. The dividend bits leave the top of the
// shift word while the quotient bits enter at the bottom.
// ----------------------------------------------------------------------------
module sdiv_cell import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sdiv_ctl_t             in_ctl,
  input  logic [DATA_WIDTH-1:0] in_rem,
  input  logic [DATA_WIDTH-1:0] in_nq,
  input  logic [DATA_WIDTH-1:0] in_den,
  output logic                  valid,
  input  logic                  out_stall,
  output sdiv_ctl_t             ctl,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [DATA_WIDTH-1:0] nq,
  output logic [DATA_WIDTH-1:0] den
);

  logic [DATA_WIDTH:0]   part;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;
  logic [DATA_WIDTH-1:0] rem_next;

  assign part     = {in_rem, in_nq[DATA_WIDTH-1]};
  assign diff     = part - {1'b0, in_den};
  assign ge       = (part >= {1'b0, in_den});
  assign rem_next = ge ? diff[DATA_WIDTH-1:0] : part[DATA_WIDTH-1:0];

  assign in_stall = valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ctl <= in_ctl;
      rem <= rem_next;
      nq  <= {in_nq[DATA_WIDTH-2:0], ge};
      den <= in_den;
    end
  end

  // With a nonzero divisor the partial remainder always stays below it.
  assert property (@(posedge clk) disable iff (rst)
    (valid && !ctl.dz) |-> (rem < den))
    else $error("sdiv_cell: partial remainder not below divisor");

endmodule

// ===== rtl/sdiv_finish.sv =====
// ----------------------------------------------------------------------------
// Signed divider result stage
// Applies the result sign, forces zero for a zero divisor, sign-extends to
// the port width and holds the result until it is taken.
// ----------------------------------------------------------------------------
module sdiv_finish import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sdiv_ctl_t              in_ctl,
  input  logic [DATA_WIDTH-1:0]  in_nq,
  output logic                   valid,
  input  logic                   out_stall,
  output logic [FIELD_WIDTH-1:0] quotient
);

  logic signed [DATA_WIDTH-1:0]  q;
  logic signed [FIELD_WIDTH-1:0] q_ext;

  // After the last cell the shift word holds only quotient bits.
  always_comb begin
    if (in_ctl.dz) begin
      q = '0;
    end else if (in_ctl.neg) begin
      q = ~in_nq + 1'b1;
    end else begin
      q = in_nq;
    end
  end

  assign q_ext    = FIELD_WIDTH'(q);
  assign in_stall = valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      quotient <= q_ext;
    end
  end

endmodule

// ===== rtl/signed_divider_64.sv =====
// ----------------------------------------------------------------------------
// Signed 64-bit divider
// Pipelined restoring divider, quotient truncated toward zero, one cell per
// quotient bit.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Direction  Payload
//  input    in_valid, in_stall               in         dividend, divisor
//  output   out_valid, out_stall             out        quotient
//
//  A transaction is taken every cycle while the output is not stalled.
//  Each transaction passes through DATA_WIDTH + 2 stages: one operand stage,
//  one cell per quotient bit, and the result register. Each stage advances
//  on its own, so bubbles collapse behind a stalled output and input is
//  stalled only when every stage holds a transaction.
//  Reset clears the stage valid bits only; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module signed_divider_64 import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FIELD_WIDTH-1:0] dividend,
  input  logic [FIELD_WIDTH-1:0] divisor,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FIELD_WIDTH-1:0] quotient
);

  localparam int STAGES = DATA_WIDTH + 2;
  localparam int CW     = $clog2(STAGES + 1);

  // Chain entry k is the output of stage k: entry 0 is the operand stage,
  // entries 1 to DATA_WIDTH are the cells.
  logic                  c_valid [DATA_WIDTH+1];
  logic                  c_stall [DATA_WIDTH+1];
  sdiv_ctl_t             c_ctl   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] c_rem   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] c_nq    [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] c_den   [DATA_WIDTH+1];

  sdiv_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dividend  (dividend),
    .divisor   (divisor),
    .valid     (c_valid[0]),
    .out_stall (c_stall[0]),
    .ctl       (c_ctl[0]),
    .rem       (c_rem[0]),
    .nq        (c_nq[0]),
    .den       (c_den[0])
  );

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    sdiv_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[k]),
      .in_stall  (c_stall[k]),
      .in_ctl    (c_ctl[k]),
      .in_rem    (c_rem[k]),
      .in_nq     (c_nq[k]),
      .in_den    (c_den[k]),
      .valid     (c_valid[k+1]),
      .out_stall (c_stall[k+1]),
      .ctl       (c_ctl[k+1]),
      .rem       (c_rem[k+1]),
      .nq        (c_nq[k+1]),
      .den       (c_den[k+1])
    );
  end

  sdiv_finish #(.DATA_WIDTH(DATA_WIDTH)) u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid[DATA_WIDTH]),
    .in_stall  (c_stall[DATA_WIDTH]),
    .in_ctl    (c_ctl[DATA_WIDTH]),
    .in_nq     (c_nq[DATA_WIDTH]),
    .valid     (out_valid),
    .out_stall (out_stall),
    .quotient  (quotient)
  );

  // Number of transactions inside the pipeline, kept for checking.
  logic [CW-1:0] in_flight;
  logic          in_take;
  logic          out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (in_take && !out_take) begin
      in_flight <= in_flight + 1'b1;
    end else if (out_take && !in_take) begin
      in_flight <= in_flight - 1'b1;
    end
  end

  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("signed_divider_64: result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("signed_divider_64: input stalled without a blocked result");

  assert property (@(posedge clk) disable iff (rst)
    in_flight <= CW'(STAGES))
    else $error("signed_divider_64: more transactions in flight than stages");

  assert property (@(posedge clk) disable iff (rst)
    (in_flight == '0) |-> !out_valid)
    else $error("signed_divider_64: result shown with an empty pipeline");

endmodule

// ===== tb/signed_divider_64_tb.sv =====
// ----------------------------------------------------------------------------
// Signed 64-bit divider testbench
// Sends directed corner operand pairs, then random pairs, through the divider.
// Each accepted transaction gets a predicted quotient in a scoreboard, and
// results are checked in order. Both channels see random idle and stall
// bursts, a long output hold that fills the pipeline, and a full drain.
// ----------------------------------------------------------------------------
module signed_divider_64_tb;
  import sdiv_pkg::*;

  localparam logic [FIELD_WIDTH-1:0] MOST_NEG = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
  localparam logic [FIELD_WIDTH-1:0] MOST_POS = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
  localparam logic [FIELD_WIDTH-1:0] MINUS_ONE = {FIELD_WIDTH{1'b1}};
  localparam logic [FIELD_WIDTH-1:0] ZERO = '0;
  localparam logic [FIELD_WIDTH-1:0] ONE = FIELD_WIDTH'(1);
  localparam int RANDOM_PAIRS = 1200;
  localparam int PIPE_LATENCY = 66;
  localparam int LONG_HOLD = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  // Holds predicted quotients in the order their operands were accepted.
  class quotient_scoreboard;
    logic [FIELD_WIDTH-1:0] expected_q[$];
    int unsigned mismatches = 0;

    // Truncating signed division; a zero divisor gives zero, and the most
    // negative value over minus one wraps back to itself.
    function logic [FIELD_WIDTH-1:0] signed_quotient(logic [FIELD_WIDTH-1:0] a,
                                                     logic [FIELD_WIDTH-1:0] b);
      logic neg;
      logic [FIELD_WIDTH-1:0] mag_a;
      logic [FIELD_WIDTH-1:0] mag_b;
      logic [FIELD_WIDTH-1:0] q;
      neg = a[FIELD_WIDTH-1] ^ b[FIELD_WIDTH-1];
      mag_a = a[FIELD_WIDTH-1] ? -a : a;
      mag_b = b[FIELD_WIDTH-1] ? -b : b;
      q = (mag_b == ZERO) ? ZERO : mag_a / mag_b;
      if (neg) q = -q;
      return q;
    endfunction

    function void note_operands(logic [FIELD_WIDTH-1:0] a, logic [FIELD_WIDTH-1:0] b);
      expected_q.push_back(signed_quotient(a, b));
    endfunction

    function void check_quotient(logic [FIELD_WIDTH-1:0] q);
      logic [FIELD_WIDTH-1:0] want;
      if (expected_q.size() == 0) begin
        $error("quotient: expected none, actual %h", q);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (q !== want) begin
          $error("quotient: expected %h, actual %h", want, q);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FIELD_WIDTH-1:0] dividend = '0;
  logic [FIELD_WIDTH-1:0] divisor = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FIELD_WIDTH-1:0] quotient;

  quotient_scoreboard sb = new();
  bit in_gaps_on = 1'b1;
  bit out_gaps_on = 1'b1;
  int hold_len = 0;
  int quiet_cycles = 0;

  signed_divider_64 dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .dividend(dividend),
    .divisor(divisor),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .quotient(quotient)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_operands(logic [FIELD_WIDTH-1:0] a, logic [FIELD_WIDTH-1:0] b);
    if (in_gaps_on && $urandom_range(0, 7) == 0) idle_input($urandom_range(1, 7));
    @(negedge clk);
    in_valid <= 1'b1;
    dividend <= a;
    divisor <= b;
    do @(posedge clk); while (in_stall);
    sb.note_operands(a, b);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mix of full-width values, values of random bit length, small values
  // and the corner values, each sign about equally often.
  function automatic logic [FIELD_WIDTH-1:0] random_operand();
    logic [FIELD_WIDTH-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      2, 3: begin
        v = v >> $urandom_range(1, FIELD_WIDTH - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      4: begin
        v = FIELD_WIDTH'($urandom_range(0, 15));
        if ($urandom_range(0, 1)) v = -v;
      end
      5: begin
        case ($urandom_range(0, 4))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = ZERO;
          3: v = ONE;
          default: v = MINUS_ONE;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // Receiver side: random stall bursts, or one long hold when requested.
  initial begin
    int n;
    forever begin
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        @(negedge clk) out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_quotient(quotient);
  end

  // A run that stops moving transactions in either direction is hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("signed_divider_64 test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send_operands(MOST_NEG, MINUS_ONE);
    send_operands(MOST_NEG, ONE);
    send_operands(MOST_NEG, MOST_NEG);
    send_operands(MOST_POS, MOST_NEG);
    send_operands(MOST_NEG, MOST_POS);
    send_operands(MOST_POS, MINUS_ONE);
    send_operands(MOST_POS, MOST_POS);
    send_operands(MOST_POS, ONE);
    send_operands(ONE, MOST_POS);
    send_operands(MINUS_ONE, MOST_NEG);
    send_operands(MOST_POS, ZERO);
    send_operands(MOST_NEG, ZERO);
    send_operands(MINUS_ONE, ZERO);
    send_operands(ZERO, ZERO);
    send_operands(ZERO, 64'd5);
    send_operands(64'd7, 64'd2);
    send_operands(-64'sd7, 64'd2);
    send_operands(64'd7, -64'sd2);
    send_operands(-64'sd7, -64'sd2);
    send_operands(MOST_NEG, 64'd2);
    send_operands(64'd3, 64'd10);
    send_operands(~64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef);
    idle_input(1);
    wait_drained();

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 150 == 0 && i < 900) begin
        in_gaps_on = ($urandom_range(0, 3) != 0);
        out_gaps_on = ($urandom_range(0, 3) != 0);
      end
      // The long hold lets the pipeline fill so that the input stalls.
      if (i == 300) hold_len = LONG_HOLD;
      if (i == 600) begin
        idle_input(1);
        wait_drained();
      end
      if (i == 900) begin
        in_gaps_on = 1'b0;
        out_gaps_on = 1'b0;
      end
      send_operands(random_operand(), random_operand());
    end
    idle_input(1);

    wait_drained();
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("signed_divider_64 test passed");
    end else begin
      $display("signed_divider_64 test failed");
    end
    $finish;
  end

endmodule
